// ===== rtl/lrhi_pkg.sv =====
// ----------------------------------------------------------------------------
// lrhi_pkg
// Shared types and constants of the loop read head interpolator: field
// widths, word kinds, register indexes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lrhi_pkg;

  localparam int POS_W      = 34;  // Q18.16 playhead
  localparam int FRAC_W     = 16;
  localparam int INT_W      = POS_W - FRAC_W;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 24;
  localparam int TLEN_W     = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int STEP_W     = POS_W + 2;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // remainder unit retires two dividend bits per cycle
  localparam int DIV_STEPS = INT_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] UNITY_MUTE = 16'd32768;
  localparam logic [15:0]       PEAK_BIAS  = 16'd999;
  // floor(x/1000) == (x * RECIP_K) >> RECIP_SH, exact for x below 2^16
  localparam logic [MUL_B_W-1:0] RECIP_K  = 18'd67109;
  localparam int                 RECIP_SH = 26;
  localparam int                 GAIN_SH  = 29;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_PLAY    = 2'd1;
  localparam logic [1:0] KIND_SET_POS = 2'd2;
  localparam logic [1:0] KIND_MUTE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_FWD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_STEP   = 3'd6;

  localparam logic [SPEED_W-1:0] RST_PLAY_SPEED = 24'd65536;
  localparam logic [GAIN_W-1:0]  RST_LEVEL_GAIN = 16'd16384;
  localparam logic [GAIN_W-1:0]  RST_MUTE_STEP  = 16'd68;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD0,
    ST_RD1,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_MUL3,
    ST_SAT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;    // word taken on the input channel
    logic div_step;
    logic rd0;       // read left neighbor, form right index
    logic rd1;       // read right neighbor, left product
    logic mul1;      // right product
    logic sum;       // round interpolation
    logic mul2;      // level gain, mute ramp, raw step
    logic mul3;      // mute gain, loop span
    logic sat;       // saturate, decay product, wrap candidates
    logic commit;    // load output word, update state
  } cmd_t;

  typedef struct packed {
    logic fits;      // integer position already below tape length, or tape length zero
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/loop_read_head_interpolator_unit.sv =====
// Play word: when the integer playhead is below the tape length it goes straight to the
// reads; otherwise the remainder unit must fold it first. The result waits in FIN while
// the output is still full. A new word is taken the cycle after the result loads; play
// words do not overlap, as there is a single tape RAM port and one shared multiplier.
// Write, set-position and set-mute words are taken in idle and give no result.
// Sync reset presets control, playhead, mute ramp, meter, config; tape RAM is not cleared.
// ----------------------------------------------------------------------------
// loop_read_head_interpolator_unit
// Looping tape read head with fractional playhead, linear interpolation,
// level and ramped mute gain, decaying peak meter and loop wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_read_head_interpolator_unit #(
  parameter int TAPE_DEPTH = 262144
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [lrhi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lrhi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_kind,
  input  wire logic [17:0]                          in_tape_address,
  input  wire logic signed [lrhi_pkg::SMP_W-1:0]    in_tape_sample,
  input  wire logic [lrhi_pkg::POS_W-1:0]           in_new_position,
  input  wire logic                                 in_mute_on,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [lrhi_pkg::SMP_W-1:0]         out_sample,
  output logic signed [lrhi_pkg::SMP_W-1:0]         out_raw_sample,
  output logic                                      out_wrapped,
  output logic [lrhi_pkg::SMP_W-1:0]                out_peak_level
);

  lrhi_pkg::cmd_t cmd;
  lrhi_pkg::sts_t sts;

  lrhi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrhi_dp #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_tape_address (in_tape_address),
    .in_tape_sample  (in_tape_sample),
    .in_new_position (in_new_position),
    .in_mute_on      (in_mute_on),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_raw_sample  (out_raw_sample),
    .out_wrapped     (out_wrapped),
    .out_peak_level  (out_peak_level)
  );

endmodule

`default_nettype wire

// ===== rtl/lrhi_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrhi_ctrl
// Sequencer for one word at a time: decodes the word kind, runs the
// remainder unit when needed and steps the shared multiplier schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhi_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_kind,
  output logic                in_ready,
  input  lrhi_pkg::sts_t      sts,
  output lrhi_pkg::cmd_t      cmd
);

  lrhi_pkg::state_t state_r;
  lrhi_pkg::state_t state_nxt;
  logic             take;

  assign in_ready = (state_r == lrhi_pkg::ST_IDLE);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrhi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrhi_pkg::ST_IDLE: begin
        if (take && (in_kind == lrhi_pkg::KIND_PLAY)) begin
          state_nxt = sts.fits ? lrhi_pkg::ST_RD0 : lrhi_pkg::ST_DIV;
        end
      end
      lrhi_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = lrhi_pkg::ST_RD0;
        end
      end
      lrhi_pkg::ST_RD0:  state_nxt = lrhi_pkg::ST_RD1;
      lrhi_pkg::ST_RD1:  state_nxt = lrhi_pkg::ST_MUL1;
      lrhi_pkg::ST_MUL1: state_nxt = lrhi_pkg::ST_SUM;
      lrhi_pkg::ST_SUM:  state_nxt = lrhi_pkg::ST_MUL2;
      lrhi_pkg::ST_MUL2: state_nxt = lrhi_pkg::ST_MUL3;
      lrhi_pkg::ST_MUL3: state_nxt = lrhi_pkg::ST_SAT;
      lrhi_pkg::ST_SAT:  state_nxt = lrhi_pkg::ST_FIN;
      lrhi_pkg::ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = lrhi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lrhi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = take;
    case (state_r)
      lrhi_pkg::ST_DIV:  cmd.div_step = 1'b1;
      lrhi_pkg::ST_RD0:  cmd.rd0      = 1'b1;
      lrhi_pkg::ST_RD1:  cmd.rd1      = 1'b1;
      lrhi_pkg::ST_MUL1: cmd.mul1     = 1'b1;
      lrhi_pkg::ST_SUM:  cmd.sum      = 1'b1;
      lrhi_pkg::ST_MUL2: cmd.mul2     = 1'b1;
      lrhi_pkg::ST_MUL3: cmd.mul3     = 1'b1;
      lrhi_pkg::ST_SAT:  cmd.sat      = 1'b1;
      lrhi_pkg::ST_FIN:  cmd.commit   = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lrhi_dp.sv =====
// ----------------------------------------------------------------------------
// lrhi_dp
// Datapath: tape RAM, config registers, playhead, remainder unit, shared
// multiplier, mute ramp, peak meter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhi_dp #(
  parameter int TAPE_DEPTH = 262144
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  lrhi_pkg::cmd_t                            cmd,
  output lrhi_pkg::sts_t                            sts,
  input  wire logic                                 cfg_we,
  input  wire logic [lrhi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lrhi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [1:0]                           in_kind,
  input  wire logic [17:0]                          in_tape_address,
  input  wire logic signed [lrhi_pkg::SMP_W-1:0]    in_tape_sample,
  input  wire logic [lrhi_pkg::POS_W-1:0]           in_new_position,
  input  wire logic                                 in_mute_on,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [lrhi_pkg::SMP_W-1:0]         out_sample,
  output logic signed [lrhi_pkg::SMP_W-1:0]         out_raw_sample,
  output logic                                      out_wrapped,
  output logic [lrhi_pkg::SMP_W-1:0]                out_peak_level
);

  localparam int ADDR_W = $clog2(TAPE_DEPTH);
  localparam int LEN_W  = $clog2(TAPE_DEPTH + 1);
  localparam int REM_W  = LEN_W + 1;

  localparam int POS_W  = lrhi_pkg::POS_W;
  localparam int FRAC_W = lrhi_pkg::FRAC_W;
  localparam int INT_W  = lrhi_pkg::INT_W;
  localparam int SMP_W  = lrhi_pkg::SMP_W;
  localparam int STEP_W = lrhi_pkg::STEP_W;

  // config
  logic [POS_W-1:0]                  loop_start_r;
  logic [POS_W-1:0]                  loop_end_r;
  logic [lrhi_pkg::TLEN_W-1:0]       tape_length_r;
  logic [lrhi_pkg::SPEED_W-1:0]      play_speed_r;
  logic                              play_forward_r;
  logic [lrhi_pkg::GAIN_W-1:0]       level_gain_r;
  logic [lrhi_pkg::GAIN_W-1:0]       mute_step_r;

  // block state
  logic [POS_W-1:0]                  pos_r;
  logic [lrhi_pkg::GAIN_W-1:0]       mute_gain_r;
  logic                              mute_target_r;
  logic [SMP_W-1:0]                  peak_r;

  // tape store
  logic signed [SMP_W-1:0]           tape_mem [TAPE_DEPTH];
  logic signed [SMP_W-1:0]           rdata_r;
  logic [ADDR_W-1:0]                 rd_addr;
  logic                              tape_we;

  // work registers
  logic [FRAC_W-1:0]                 frac_r;
  logic [INT_W-1:0]                  dvd_r;
  logic [LEN_W-1:0]                  rem_r;
  logic [lrhi_pkg::DIV_CNT_W-1:0]    div_cnt_r;
  logic [ADDR_W-1:0]                 i0_r;
  logic [ADDR_W-1:0]                 i1_r;
  logic signed [lrhi_pkg::MUL_P_W-1:0] mul_r;
  logic signed [lrhi_pkg::MUL_P_W-1:0] p0_r;
  logic signed [SMP_W-1:0]           raw_r;
  logic signed [SMP_W-1:0]           y_r;
  logic [STEP_W-1:0]                 step_r;
  logic [POS_W-1:0]                  span_r;
  logic                              loop_ok_r;
  logic [STEP_W-1:0]                 lo_wrap_r;
  logic [STEP_W-1:0]                 hi_wrap_r;
  logic                              below_r;
  logic                              above_r;

  logic                              out_valid_r;
  logic signed [SMP_W-1:0]           out_sample_r;
  logic signed [SMP_W-1:0]           out_raw_r;
  logic                              out_wrapped_r;
  logic [SMP_W-1:0]                  out_peak_r;

  // combinational
  logic [LEN_W-1:0]                  len_eff;
  logic                              len_zero;
  logic [INT_W-1:0]                  pos_int;
  logic [REM_W-1:0]                  r1;
  logic [REM_W-1:0]                  r2;
  logic [LEN_W-1:0]                  rem_nxt;
  logic [LEN_W-1:0]                  i0_inc;
  logic [ADDR_W-1:0]                 i1_nxt;
  logic signed [lrhi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lrhi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lrhi_pkg::MUL_P_W-1:0] mul_p;
  logic [33:0]                       interp_sum;
  logic signed [SMP_W-1:0]           raw_nxt;
  logic [lrhi_pkg::GAIN_W-1:0]       st_eff;
  logic [lrhi_pkg::GAIN_W:0]         mute_up;
  logic [lrhi_pkg::GAIN_W-1:0]       mute_nxt;
  logic [STEP_W-1:0]                 step_nxt;
  logic [47:0]                       gain_rnd;
  logic signed [18:0]                gain_q;
  logic signed [SMP_W-1:0]           y_nxt;
  logic [SMP_W-1:0]                  mag;
  logic [SMP_W-1:0]                  decay_q;
  logic [SMP_W-1:0]                  peak_nxt;
  logic [POS_W-1:0]                  pos_nxt;
  logic                              wrapped_nxt;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_start_r   <= '0;
      loop_end_r     <= '0;
      tape_length_r  <= '0;
      play_speed_r   <= lrhi_pkg::RST_PLAY_SPEED;
      play_forward_r <= 1'b1;
      level_gain_r   <= lrhi_pkg::RST_LEVEL_GAIN;
      mute_step_r    <= lrhi_pkg::RST_MUTE_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        lrhi_pkg::CFG_LOOP_START:  loop_start_r   <= cfg_data;
        lrhi_pkg::CFG_LOOP_END:    loop_end_r     <= cfg_data;
        lrhi_pkg::CFG_TAPE_LENGTH: tape_length_r  <= cfg_data[lrhi_pkg::TLEN_W-1:0];
        lrhi_pkg::CFG_PLAY_SPEED:  play_speed_r   <= cfg_data[lrhi_pkg::SPEED_W-1:0];
        lrhi_pkg::CFG_PLAY_FWD:    play_forward_r <= cfg_data[0];
        lrhi_pkg::CFG_LEVEL_GAIN:  level_gain_r   <= cfg_data[lrhi_pkg::GAIN_W-1:0];
        lrhi_pkg::CFG_MUTE_STEP:   mute_step_r    <= cfg_data[lrhi_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- index
  assign len_eff  = (32'(tape_length_r) > 32'(TAPE_DEPTH)) ? LEN_W'(TAPE_DEPTH)
                                                           : LEN_W'(tape_length_r);
  assign len_zero = (len_eff == '0);
  assign pos_int  = pos_r[POS_W-1:FRAC_W];

  // remainder unit: two restoring steps per cycle
  always_comb begin
    r1 = {rem_r, dvd_r[INT_W-1]};
    if (r1 >= REM_W'(len_eff)) begin
      r1 = r1 - REM_W'(len_eff);
    end
    r2 = {r1[LEN_W-1:0], dvd_r[INT_W-2]};
    if (r2 >= REM_W'(len_eff)) begin
      r2 = r2 - REM_W'(len_eff);
    end
    rem_nxt = r2[LEN_W-1:0];
  end

  assign i0_inc = LEN_W'(i0_r) + LEN_W'(1);
  assign i1_nxt = (i0_inc == len_eff) ? '0 : ADDR_W'(i0_inc);

  assign sts.fits     = len_zero || (32'(pos_int) < 32'(len_eff));
  assign sts.div_last = (div_cnt_r == lrhi_pkg::DIV_CNT_W'(lrhi_pkg::DIV_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------- tape RAM
  assign tape_we = cmd.accept && (in_kind == lrhi_pkg::KIND_WRITE) &&
                   (32'(in_tape_address) < 32'(TAPE_DEPTH));
  assign rd_addr = cmd.rd1 ? i1_r : i0_r;

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[ADDR_W'(in_tape_address)] <= in_tape_sample;
    end
    rdata_r <= tape_mem[rd_addr];
  end

  // ---------------------------------------------------------------- multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.rd1) begin
      mul_a = lrhi_pkg::MUL_A_W'(rdata_r);
      mul_b = lrhi_pkg::MUL_B_W'(1 << FRAC_W) - {2'b00, frac_r};
    end else if (cmd.mul1) begin
      mul_a = lrhi_pkg::MUL_A_W'(rdata_r);
      mul_b = {2'b00, frac_r};
    end else if (cmd.mul2) begin
      mul_a = lrhi_pkg::MUL_A_W'(raw_r);
      mul_b = {2'b00, level_gain_r};
    end else if (cmd.mul3) begin
      mul_a = mul_r[lrhi_pkg::MUL_A_W-1:0];
      mul_b = {2'b00, mute_gain_r};
    end else if (cmd.sat) begin
      mul_a = {17'd0, peak_r + lrhi_pkg::PEAK_BIAS};
      mul_b = lrhi_pkg::RECIP_K;
    end
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------- arithmetic
  assign interp_sum = p0_r[33:0] + mul_r[33:0] + 34'd32768;
  assign raw_nxt    = len_zero ? '0 : interp_sum[31:16];

  assign st_eff   = (mute_step_r == '0) ? 16'd1 : mute_step_r;
  assign mute_up  = {1'b0, mute_gain_r} + {1'b0, st_eff};
  always_comb begin
    if (mute_target_r) begin
      mute_nxt = (mute_gain_r > st_eff) ? (mute_gain_r - st_eff) : '0;
    end else begin
      mute_nxt = (mute_up > {1'b0, lrhi_pkg::UNITY_MUTE}) ? lrhi_pkg::UNITY_MUTE
                                                          : mute_up[lrhi_pkg::GAIN_W-1:0];
    end
  end

  assign step_nxt = play_forward_r ? ({2'b00, pos_r} + {12'd0, play_speed_r})
                                   : ({2'b00, pos_r} - {12'd0, play_speed_r});

  assign gain_rnd = mul_r[47:0] + (48'd1 << (lrhi_pkg::GAIN_SH - 1));
  assign gain_q   = gain_rnd[47:lrhi_pkg::GAIN_SH];
  always_comb begin
    if (gain_q > 19'sd32767) begin
      y_nxt = 16'sh7fff;
    end else if (gain_q < -19'sd32768) begin
      y_nxt = 16'sh8000;
    end else begin
      y_nxt = gain_q[SMP_W-1:0];
    end
  end

  // mag of -32768 comes out as 0x8000, which is right read unsigned
  assign mag      = y_r[SMP_W-1] ? (~y_r + 16'd1) : y_r;
  assign decay_q  = {10'd0, mul_r[lrhi_pkg::RECIP_SH+5:lrhi_pkg::RECIP_SH]};
  assign peak_nxt = (mag > peak_r) ? mag : (peak_r - decay_q);

  always_comb begin
    pos_nxt     = pos_r;
    wrapped_nxt = 1'b0;
    if (loop_ok_r) begin
      wrapped_nxt = below_r || above_r;
      if (below_r) begin
        pos_nxt = lo_wrap_r[POS_W-1:0];
      end else if (above_r) begin
        pos_nxt = hi_wrap_r[POS_W-1:0];
      end else begin
        pos_nxt = step_r[POS_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- work regs
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      frac_r    <= pos_r[FRAC_W-1:0];
      dvd_r     <= pos_int;
      rem_r     <= '0;
      div_cnt_r <= '0;
      i0_r      <= ADDR_W'(pos_int);
    end
    if (cmd.div_step) begin
      dvd_r     <= {dvd_r[INT_W-3:0], 2'b00};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + lrhi_pkg::DIV_CNT_W'(1);
      i0_r      <= ADDR_W'(rem_nxt);
    end
    if (cmd.rd0) begin
      i1_r <= i1_nxt;
    end
    if (cmd.rd1 || cmd.mul1 || cmd.mul2 || cmd.mul3 || cmd.sat) begin
      mul_r <= mul_p;
    end
    if (cmd.mul1) begin
      p0_r <= mul_r;
    end
    if (cmd.sum) begin
      raw_r <= raw_nxt;
    end
    if (cmd.mul2) begin
      step_r <= step_nxt;
    end
    if (cmd.mul3) begin
      span_r    <= loop_end_r - loop_start_r;
      loop_ok_r <= loop_end_r > loop_start_r;
    end
    if (cmd.sat) begin
      y_r       <= y_nxt;
      lo_wrap_r <= step_r + {2'b00, span_r};
      hi_wrap_r <= step_r - {2'b00, span_r};
      below_r   <= $signed(step_r) < $signed({2'b00, loop_start_r});
      above_r   <= $signed(step_r) >= $signed({2'b00, loop_end_r});
    end
    if (cmd.commit) begin
      out_sample_r  <= y_r;
      out_raw_r     <= raw_r;
      out_wrapped_r <= wrapped_nxt;
      out_peak_r    <= peak_nxt;
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      mute_gain_r   <= lrhi_pkg::UNITY_MUTE;
      mute_target_r <= 1'b0;
      peak_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.accept && (in_kind == lrhi_pkg::KIND_SET_POS)) begin
        pos_r <= in_new_position;
      end
      if (cmd.accept && (in_kind == lrhi_pkg::KIND_MUTE)) begin
        mute_target_r <= in_mute_on;
      end
      if (cmd.mul2) begin
        mute_gain_r <= mute_nxt;
      end
      if (cmd.commit) begin
        pos_r  <= pos_nxt;
        peak_r <= peak_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_raw_sample = out_raw_r;
  assign out_wrapped    = out_wrapped_r;
  assign out_peak_level = out_peak_r;

  // ---------------------------------------------------------------- checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd0 && !len_zero) |-> (LEN_W'(i0_r) < len_eff))
    else $error("left tap index not below tape length");

  a_mute_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    mute_gain_r <= lrhi_pkg::UNITY_MUTE)
    else $error("mute gain above unity");

  a_peak_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= 16'd32768)
    else $error("peak meter above full scale");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid && (out_peak_level == peak_r)))
    else $error("committed word not presented");

endmodule

`default_nettype wire

// ===== tb/lrhi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrhi_checker
// Watches the configuration port and both word channels of the loop read
// head. It keeps its own copy of the tape, playhead, mute ramp, meter and
// registers, predicts each play result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhi_checker
  import lrhi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic [1:0]               in_kind,
  input  wire logic [17:0]              in_tape_address,
  input  wire logic signed [SMP_W-1:0]  in_tape_sample,
  input  wire logic [POS_W-1:0]         in_new_position,
  input  wire logic                     in_mute_on,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic signed [SMP_W-1:0]  out_sample,
  input  wire logic signed [SMP_W-1:0]  out_raw_sample,
  input  wire logic                     out_wrapped,
  input  wire logic [SMP_W-1:0]         out_peak_level,
  output int                            fail_count,
  output int                            plays_due,
  output int                            plays_checked,
  output int                            wraps_seen
);

  localparam int  STORE_DEPTH = 262144;
  localparam longint SMP_HI   = 32767;
  localparam longint SMP_LO   = -32768;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic signed [SMP_W-1:0] raw;
    logic                    wrapped;
    logic [SMP_W-1:0]        peak;
  } play_word_t;

  logic signed [SMP_W-1:0] tape [STORE_DEPTH];
  logic [POS_W-1:0]        head;
  logic [GAIN_W-1:0]       mute_gain;
  logic                    mute_to_zero;
  logic [SMP_W-1:0]        meter;

  logic [POS_W-1:0]        r_start;
  logic [POS_W-1:0]        r_end;
  logic [TLEN_W-1:0]       r_len;
  logic [SPEED_W-1:0]      r_speed;
  logic                    r_fwd;
  logic [GAIN_W-1:0]       r_gain;
  logic [GAIN_W-1:0]       r_step;

  play_word_t due_plays[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [SMP_W-1:0] got,
                             input logic [SMP_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("play %0d %s got %h want %h", plays_checked, name,
                                got, want));
  endtask

  // linear interpolation between the two neighbors at pos, rounded half up
  function automatic longint tape_interp(input logic [POS_W-1:0] pos);
    longint unsigned span;
    longint unsigned ip;
    int              idx0;
    int              idx1;
    longint          frac;
    longint          s0;
    longint          s1;
    longint          acc;
    span = (r_len > TLEN_W'(STORE_DEPTH)) ? 64'(STORE_DEPTH) : 64'(r_len);
    if (span == 0) return 0;
    ip   = 64'(pos >> FRAC_W);
    idx0 = int'(ip % span);
    idx1 = int'((longint'(idx0) + 1) % span);
    frac = longint'(pos[FRAC_W-1:0]);
    s0   = longint'(tape[idx0]);
    s1   = longint'(tape[idx1]);
    acc  = s0 * ((64'sd1 <<< FRAC_W) - frac) + s1 * frac;
    return (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic play_word_t next_play_word();
    play_word_t      w;
    longint          raw;
    longint          lvl;
    longint          mg;
    longint          y;
    longint          p;
    longint          lo;
    longint          hi;
    longint          spd;
    int unsigned     st;
    int unsigned     g;
    int unsigned     mag;
    raw = tape_interp(head);

    // mute ramp moves first, the stepped gain is the one applied
    st = (r_step == 0) ? 32'd1 : 32'(r_step);
    if (mute_to_zero) begin
      mute_gain = (32'(mute_gain) > st) ? GAIN_W'(32'(mute_gain) - st) : '0;
    end else begin
      g = 32'(mute_gain) + st;
      mute_gain = (g > 32'(UNITY_MUTE)) ? UNITY_MUTE : GAIN_W'(g);
    end

    lvl = longint'(r_gain);
    mg  = longint'(mute_gain);
    y   = (raw * lvl * mg + (64'sd1 <<< (GAIN_SH - 1))) >>> GAIN_SH;
    if (y > SMP_HI) y = SMP_HI;
    if (y < SMP_LO) y = SMP_LO;

    mag = (y < 0) ? int'(-y) : int'(y);
    if (mag > 32'(meter)) meter = SMP_W'(mag);
    else meter = SMP_W'((int'(meter) * 999) / 1000);

    w.wrapped = 1'b0;
    if (r_end > r_start) begin
      p   = longint'(head);
      lo  = longint'(r_start);
      hi  = longint'(r_end);
      spd = longint'(r_speed);
      p   = r_fwd ? p + spd : p - spd;
      // a single fold only; a far-out playhead stays outside the loop
      if (p < lo) begin
        p += hi - lo;
        w.wrapped = 1'b1;
      end else if (p >= hi) begin
        p -= hi - lo;
        w.wrapped = 1'b1;
      end
      head = p[POS_W-1:0];
    end

    w.sample = y[SMP_W-1:0];
    w.raw    = raw[SMP_W-1:0];
    w.peak   = meter;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    play_word_t want;
    if (!rst_n) begin
      head          = '0;
      mute_gain     = UNITY_MUTE;
      mute_to_zero  = 1'b0;
      meter         = '0;
      r_start       = '0;
      r_end         = '0;
      r_len         = '0;
      r_speed       = RST_PLAY_SPEED;
      r_fwd         = 1'b1;
      r_gain        = RST_LEVEL_GAIN;
      r_step        = RST_MUTE_STEP;
      fail_count    = 0;
      plays_checked = 0;
      wraps_seen    = 0;
      due_plays.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_plays.size() == 0) begin
          report_mismatch("result word with no play pending");
        end else begin
          want = due_plays.pop_front();
          check_field("out_sample", out_sample, want.sample);
          check_field("raw_sample", out_raw_sample, want.raw);
          check_field("wrapped", SMP_W'(out_wrapped), SMP_W'(want.wrapped));
          check_field("peak_level", out_peak_level, want.peak);
          plays_checked++;
          if (want.wrapped) wraps_seen++;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_LOOP_START:  r_start = cfg_data[POS_W-1:0];
          CFG_LOOP_END:    r_end   = cfg_data[POS_W-1:0];
          CFG_TAPE_LENGTH: r_len   = cfg_data[TLEN_W-1:0];
          CFG_PLAY_SPEED:  r_speed = cfg_data[SPEED_W-1:0];
          CFG_PLAY_FWD:    r_fwd   = cfg_data[0];
          CFG_LEVEL_GAIN:  r_gain  = cfg_data[GAIN_W-1:0];
          CFG_MUTE_STEP:   r_step  = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        case (in_kind)
          KIND_WRITE:   tape[in_tape_address] = in_tape_sample;
          KIND_PLAY:    due_plays.push_back(next_play_word());
          KIND_SET_POS: head = in_new_position;
          KIND_MUTE:    mute_to_zero = in_mute_on;
          default: ;
        endcase
      end
    end
    plays_due <= due_plays.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_loop_read_head_interpolator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_loop_read_head_interpolator_unit
// Drives tape writes, plays, position and mute words into the loop read head
// under several register settings, with random gaps on both channels; the
// checker beside the block predicts and compares every play result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_loop_read_head_interpolator_unit;
  import lrhi_pkg::*;

  localparam int QUIET_CYCLES = 24;    // covers the slow play path with margin
  localparam int STALL_LIMIT  = 4000;
  localparam int FILL         = 64;    // tape entries written in the initial fill
  localparam int BIG_BASE     = 262136;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 85;
  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam logic [POS_W-1:0] BIG_LO  = {18'(BIG_BASE), 16'h0000};

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_kind;
  logic [17:0]             in_tape_address;
  logic signed [SMP_W-1:0] in_tape_sample;
  logic [POS_W-1:0]        in_new_position;
  logic                    in_mute_on;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SMP_W-1:0] out_sample;
  logic signed [SMP_W-1:0] out_raw_sample;
  logic                    out_wrapped;
  logic [SMP_W-1:0]        out_peak_level;

  int fail_count;
  int plays_due;
  int plays_checked;
  int wraps_seen;

  bit               calm;
  bit               big_tape;
  logic [POS_W-1:0] loop_lo;
  logic [POS_W-1:0] loop_hi;

  always #5 clk = ~clk;

  loop_read_head_interpolator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_tape_address (in_tape_address),
    .in_tape_sample  (in_tape_sample),
    .in_new_position (in_new_position),
    .in_mute_on      (in_mute_on),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_raw_sample  (out_raw_sample),
    .out_wrapped     (out_wrapped),
    .out_peak_level  (out_peak_level)
  );

  lrhi_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_tape_address (in_tape_address),
    .in_tape_sample  (in_tape_sample),
    .in_new_position (in_new_position),
    .in_mute_on      (in_mute_on),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_raw_sample  (out_raw_sample),
    .out_wrapped     (out_wrapped),
    .out_peak_level  (out_peak_level),
    .fail_count      (fail_count),
    .plays_due       (plays_due),
    .plays_checked   (plays_checked),
    .wraps_seen      (wraps_seen)
  );

  function automatic logic [POS_W-1:0] rand_pos();
    return {2'($urandom_range(0, 3)), 32'($urandom())};
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  // somewhere inside the current loop; callers make sure the loop is valid
  function automatic logic [POS_W-1:0] pos_in_loop();
    return loop_lo + (rand_pos() % (loop_hi - loop_lo));
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [17:0] addr,
                           input logic [SMP_W-1:0] smp, input logic [POS_W-1:0] pos,
                           input logic mute);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_tape_address <= addr;
    in_tape_sample  <= smp;
    in_new_position <= pos;
    in_mute_on      <= mute;
    do @(posedge clk); while (!in_ready);
  endtask

  // unused fields carry random noise
  task automatic play();
    send_word(KIND_PLAY, 18'($urandom()), SMP_W'($urandom()), rand_pos(), 1'($urandom()));
  endtask

  task automatic set_pos(input logic [POS_W-1:0] pos);
    send_word(KIND_SET_POS, 18'($urandom()), SMP_W'($urandom()), pos, 1'($urandom()));
  endtask

  task automatic set_mute(input logic mute);
    send_word(KIND_MUTE, 18'($urandom()), SMP_W'($urandom()), rand_pos(), mute);
  endtask

  task automatic write_tape(input logic [17:0] addr, input logic [SMP_W-1:0] smp);
    send_word(KIND_WRITE, addr, smp, rand_pos(), 1'($urandom()));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (plays_due != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                           input logic [TLEN_W-1:0] len, input logic [SPEED_W-1:0] spd,
                           input logic fwd, input logic [GAIN_W-1:0] gain,
                           input logic [GAIN_W-1:0] step);
    wait_idle();
    write_reg(CFG_LOOP_START, lo);
    write_reg(CFG_LOOP_END, hi);
    write_reg(CFG_TAPE_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_PLAY_SPEED, CFG_DATA_W'(spd));
    write_reg(CFG_PLAY_FWD, CFG_DATA_W'(fwd));
    write_reg(CFG_LEVEL_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_MUTE_STEP, CFG_DATA_W'(step));
    cfg_we  <= 1'b0;
    loop_lo  = lo;
    loop_hi  = hi;
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      play();
    end else if (pick < 70) begin
      if (big_tape && pick < 58) write_tape(18'(BIG_BASE + $urandom_range(0, 7)), pick_sample());
      else if (!big_tape && pick < 62) write_tape(18'($urandom_range(0, FILL - 1)), pick_sample());
      else write_tape(18'($urandom()), pick_sample());
    end else if (pick < 85) begin
      // with the full-depth tape the loop lies over the top entries; the last one wraps to entry 0
      if (big_tape || (loop_hi > loop_lo && pick < 80)) set_pos(pos_in_loop());
      else set_pos(rand_pos());
    end else begin
      set_mute(1'($urandom()));
    end
  endtask

  task automatic pick_phase_regs(input int ph);
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [TLEN_W-1:0]  len;
    logic [SPEED_W-1:0] spd;
    logic               fwd;
    logic [GAIN_W-1:0]  gain;
    logic [GAIN_W-1:0]  step;
    lo = {18'($urandom_range(0, 100)), 16'($urandom())};
    hi = lo + {18'($urandom_range(0, 31)), 16'($urandom())} + 34'd1;
    case ($urandom_range(0, 9))
      0: hi = lo;
      1: hi = lo - 34'($urandom_range(1, 1000));
      2: begin
        lo = rand_pos();
        hi = rand_pos();
      end
      default: ;
    endcase
    len  = ($urandom_range(0, 9) == 0) ? '0 : TLEN_W'($urandom_range(1, FILL));
    spd  = ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom())
                                       : SPEED_W'($urandom_range(0, 3 << 16));
    fwd  = 1'($urandom());
    case ($urandom_range(0, 7))
      0: gain = '0;
      1: gain = '1;
      default: gain = GAIN_W'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0: step = '0;
      1: step = '1;
      2: step = 16'h8000;
      default: step = GAIN_W'($urandom_range(1, 3000));
    endcase
    if (ph == 0) begin
      // smallest settings: one-step loop, one-sample tape, no motion, no gain
      lo = '0; hi = 34'd1; len = 19'd1; spd = '0; fwd = 1'b0; gain = '0; step = '0;
    end else if (ph == 1) begin
      lo = '0; hi = POS_TOP; len = 19'(FILL); spd = '1; fwd = 1'b1; gain = '1; step = '1;
    end
    load_regs(lo, hi, len, spd, fwd, gain, step);
  endtask

  initial begin : result_sink
    out_ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("[loop_read_head_interpolator_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int ph;
    calm     = 1'b0;
    big_tape = 1'b0;
    loop_lo  = '0;
    loop_hi  = '0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_WRITE;
    in_tape_address <= '0;
    in_tape_sample  <= '0;
    in_new_position <= '0;
    in_mute_on      <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty tape gives silence, invalid loop holds the playhead
    play();
    set_mute(1'b1);
    play();
    set_mute(1'b0);

    write_tape(18'd0, 16'h7FFF);
    write_tape(18'd1, 16'h8000);
    write_tape(18'd2, 16'h0000);
    write_tape(18'd3, 16'hFFFF);
    for (int a = 4; a < FILL; a++) write_tape(18'(a), pick_sample());
    write_tape(18'h3FFFF, pick_sample());

    // full-scale gain drives both saturation limits; fastest mute ramp
    load_regs('0, {18'(FILL), 16'h0}, 19'(FILL), 24'h008000, 1'b1, 16'hFFFF, 16'h8000);
    set_pos('0);
    play();
    set_pos({18'd1, 16'h8000});
    play();
    set_mute(1'b1);
    play();
    set_mute(1'b0);
    play();
    // one fold cannot bring the top position back inside
    set_pos(POS_TOP);
    play();
    play();

    // backward at top speed from below the loop; zero mute step acts as one
    load_regs({18'd10, 16'h0}, {18'd20, 16'h0}, 19'(FILL), '1, 1'b0, 16'h4000, '0);
    set_pos('0);
    play();
    set_mute(1'b1);
    play();
    play();
    set_pos({18'd15, 16'h0});
    play();

    // tape length beyond the store, then exactly the store depth
    big_tape = 1'b1;
    for (int a = BIG_BASE; a < BIG_BASE + 8; a++) write_tape(18'(a), pick_sample());
    for (int k = 0; k < 2; k++) begin
      load_regs(BIG_LO, POS_TOP, (k == 0) ? 19'h7FFFF : 19'h40000,
                SPEED_W'($urandom_range(0, 19'h7FFFF)), 1'(k), GAIN_W'($urandom()),
                GAIN_W'($urandom_range(1, 3000)));
      set_pos(pos_in_loop());
      repeat (30) random_word();
    end
    big_tape = 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      pick_phase_regs(ph);
      calm = (ph == PHASES - 1);
      repeat (PHASE_WORDS) random_word();
    end

    wait_idle();
    $display("covered: %0d play results checked, %0d of them with a loop wrap", plays_checked,
             wraps_seen);
    $display("covered: empty, small and over-depth tapes, both directions, mute ramps");
    if (fail_count == 0) begin
      $display("[loop_read_head_interpolator_unit] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[loop_read_head_interpolator_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
